[rtl/fcc_pkg.sv]
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared widths, register map, reset values and the control-store program of
// the fan curve controller.
// ----------------------------------------------------------------------------
package fcc_pkg;

  // Number of points in the fan curve (2 to 10).
  localparam int NUM_POINTS = 10;
  // Two points are packed into each curve register.
  localparam int CURVE_REGS = 5;

  // Field widths.
  localparam int TEMP_MILLI_W = 18;
  localparam int TEMP_W       = 8;
  localparam int PCT_W        = 7;
  localparam int PWM_W        = 8;
  localparam int PADDR_W      = 5;
  localparam int PDATA_W      = 32;

  // Point index width, enough for NUM_POINTS plus one at any value in range.
  localparam int IDX_W = 4;

  // Register map: index is paddr[4:2].
  localparam logic [2:0] REG_CURVE_0_1 = 3'd0;
  localparam logic [2:0] REG_CURVE_2_3 = 3'd1;
  localparam logic [2:0] REG_CURVE_4_5 = 3'd2;
  localparam logic [2:0] REG_CURVE_6_7 = 3'd3;
  localparam logic [2:0] REG_CURVE_8_9 = 3'd4;
  localparam logic [2:0] REG_FLOOR     = 3'd5;
  localparam logic [2:0] REG_CEIL      = 3'd6;

  // Reset values.
  localparam logic [31:0] CURVE_RST_0_1 = 32'd2418868224;
  localparam logic [31:0] CURVE_RST_2_3 = 32'd2990317111;
  localparam logic [31:0] CURVE_RST_4_5 = 32'd3825263696;
  localparam logic [31:0] CURVE_RST_6_7 = 32'd3825263616;
  localparam logic [31:0] CURVE_RST_8_9 = 32'd3825263616;
  localparam logic [7:0]  FLOOR_RST     = 8'd0;
  localparam logic [7:0]  CEIL_RST      = 8'd255;

  // Millidegrees to degrees: multiply by ceil(2^28 / 1000) and shift by 28.
  // The error stays below 1/1000 over the whole 18-bit input range.
  localparam logic [18:0] DEG_RECIP = 19'd268436;
  localparam int          DEG_SHIFT = 28;

  localparam logic [7:0] TEMP_MAX  = 8'd255;
  localparam logic [7:0] HYST      = 8'd5;
  localparam logic [6:0] PCT_FULL  = 7'd100;
  localparam logic [2:0] DIV_LAST  = 3'd7;

  // One curve point as packed in half a register.
  typedef struct packed {
    logic       interp;
    logic [6:0] pct;
    logic [7:0] temp;
  } point_t;

  // Sequencer step addresses.
  typedef logic [3:0] step_t;
  localparam step_t S_ACCEPT  = 4'd0;
  localparam step_t S_CONV    = 4'd1;
  localparam step_t S_TRACK   = 4'd2;
  localparam step_t S_WALK    = 4'd3;
  localparam step_t S_NOMATCH = 4'd4;
  localparam step_t S_DIRECT  = 4'd5;
  localparam step_t S_IMUL    = 4'd6;
  localparam step_t S_IDIV    = 4'd7;
  localparam step_t S_IDONE   = 4'd8;
  localparam step_t S_CHECK   = 4'd9;
  localparam step_t S_SDIV    = 4'd10;
  localparam step_t S_SDONE   = 4'd11;
  localparam step_t S_WRITE   = 4'd12;
  localparam step_t S_WRAP    = 4'd13;
  localparam step_t S_FAIL    = 4'd14;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_CONV,
    OP_TRACK,
    OP_WALK,
    OP_MUL_INTERP,
    OP_DIV,
    OP_INTERP_DONE,
    OP_SCALE_SETUP,
    OP_SCALE_DONE,
    OP_WRITE,
    OP_FAIL
  } op_t;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_IN,
    C_WALK_MORE,
    C_NOMATCH,
    C_DIRECT,
    C_DIV_MORE,
    C_PCT_BAD,
    C_OUT_BUSY
  } cond_t;

  // One control word: operation, jump condition and jump target.
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  // Control store. When the condition holds the sequencer jumps to the
  // target, otherwise it moves on to the following step.
  function automatic uword_t ucode(step_t s);
    uword_t w;
    case (s)
      S_ACCEPT:  w = '{op: OP_LOAD,        cond: C_NO_IN,     target: S_ACCEPT};
      S_CONV:    w = '{op: OP_CONV,        cond: C_NEXT,      target: S_ACCEPT};
      S_TRACK:   w = '{op: OP_TRACK,       cond: C_NEXT,      target: S_ACCEPT};
      S_WALK:    w = '{op: OP_WALK,        cond: C_WALK_MORE, target: S_WALK};
      S_NOMATCH: w = '{op: OP_NOP,         cond: C_NOMATCH,   target: S_FAIL};
      S_DIRECT:  w = '{op: OP_NOP,         cond: C_DIRECT,    target: S_CHECK};
      S_IMUL:    w = '{op: OP_MUL_INTERP,  cond: C_NEXT,      target: S_ACCEPT};
      S_IDIV:    w = '{op: OP_DIV,         cond: C_DIV_MORE,  target: S_IDIV};
      S_IDONE:   w = '{op: OP_INTERP_DONE, cond: C_NEXT,      target: S_ACCEPT};
      S_CHECK:   w = '{op: OP_SCALE_SETUP, cond: C_PCT_BAD,   target: S_FAIL};
      S_SDIV:    w = '{op: OP_DIV,         cond: C_DIV_MORE,  target: S_SDIV};
      S_SDONE:   w = '{op: OP_SCALE_DONE,  cond: C_NEXT,      target: S_ACCEPT};
      S_WRITE:   w = '{op: OP_WRITE,       cond: C_OUT_BUSY,  target: S_WRITE};
      S_WRAP:    w = '{op: OP_NOP,         cond: C_ALWAYS,    target: S_ACCEPT};
      S_FAIL:    w = '{op: OP_FAIL,        cond: C_ALWAYS,    target: S_WRITE};
      default:   w = '{op: OP_NOP,         cond: C_ALWAYS,    target: S_ACCEPT};
    endcase
    return w;
  endfunction

endpackage

[rtl/fcc_in_if.sv]
// ----------------------------------------------------------------------------
// fcc_in_if
// Request channel carrying one temperature sample in millidegrees.
// ----------------------------------------------------------------------------
interface fcc_in_if import fcc_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic [TEMP_MILLI_W-1:0] temp_milli;

  modport source (output valid, output temp_milli, input ready);
  modport sink   (input valid, input temp_milli, output ready);

endinterface

[rtl/fcc_out_if.sv]
// ----------------------------------------------------------------------------
// fcc_out_if
// Result channel carrying the PWM value, duty and temperatures of one request.
// ----------------------------------------------------------------------------
interface fcc_out_if import fcc_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [PWM_W-1:0]  pwm_value;
  logic [PCT_W-1:0]  duty_pct;
  logic [TEMP_W-1:0] tracked_temp_out;
  logic [TEMP_W-1:0] real_temp;
  logic              valid_res;

  modport source (output valid, output pwm_value, output duty_pct,
                  output tracked_temp_out, output real_temp, output valid_res,
                  input ready);
  modport sink   (input valid, input pwm_value, input duty_pct,
                  input tracked_temp_out, input real_temp, input valid_res,
                  output ready);

endinterface

[rtl/fan_curve_controller.sv]
// Each request is converted and tracked, walks the curve, is optionally
// interpolated and is scaled to PWM (a failure skips to the write), then waits
// in the write step while an earlier result has not drained; the curve walk
// takes one point per cycle, and each of the two divisions (interpolation and
// PWM scaling) runs in the shared radix-4 divider. A new request is accepted
// only after the write and wrap steps. Reset (rst, synchronous) restores the registers and clears tracking.
// ----------------------------------------------------------------------------
// fan_curve_controller
// Microcoded fan curve controller: converts a millidegree sample to degrees,
// applies falling hysteresis, walks the curve and scales the duty to PWM.
// ----------------------------------------------------------------------------
module fan_curve_controller import fcc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  fcc_in_if.sink             in_ch,
  fcc_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  typedef enum logic [1:0] {
    W_MORE,
    W_DIRECT,
    W_INTERP,
    W_NOMATCH
  } walk_t;

  // Configuration registers.
  logic [31:0] cfg_curve [CURVE_REGS];
  logic [7:0]  pwm_floor;
  logic [7:0]  pwm_ceiling;

  // Sequencer.
  step_t  step;
  step_t  step_next;
  uword_t uw;
  logic   jump;

  // Datapath registers.
  logic [TEMP_MILLI_W-1:0] milli;
  logic [TEMP_W-1:0]       deg;
  logic [TEMP_W-1:0]       tracked;
  logic [IDX_W-1:0]        idx;
  point_t                  cur_pt;
  logic                    w_direct;
  logic                    w_nomatch;
  logic [PCT_W-1:0]        pct;
  logic [7:0]              mag;
  logic [7:0]              dt;
  logic [7:0]              den;
  logic                    neg;
  logic [15:0]             quo;
  logic [7:0]              rem;
  logic [2:0]              div_cnt;

  // Staged result and output register.
  logic [PWM_W-1:0]  res_pwm;
  logic [PCT_W-1:0]  res_pct;
  logic              res_ok;
  logic              out_valid;
  logic [PWM_W-1:0]  out_pwm;
  logic [PCT_W-1:0]  out_pct;
  logic [TEMP_W-1:0] out_track;
  logic [TEMP_W-1:0] out_deg;
  logic              out_ok;

  // APB decode.
  logic       wr_en;
  logic [2:0] reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_curve[0] <= CURVE_RST_0_1;
      cfg_curve[1] <= CURVE_RST_2_3;
      cfg_curve[2] <= CURVE_RST_4_5;
      cfg_curve[3] <= CURVE_RST_6_7;
      cfg_curve[4] <= CURVE_RST_8_9;
      pwm_floor    <= FLOOR_RST;
      pwm_ceiling  <= CEIL_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CURVE_0_1: cfg_curve[0] <= pwdata;
        REG_CURVE_2_3: cfg_curve[1] <= pwdata;
        REG_CURVE_4_5: cfg_curve[2] <= pwdata;
        REG_CURVE_6_7: cfg_curve[3] <= pwdata;
        REG_CURVE_8_9: cfg_curve[4] <= pwdata;
        REG_FLOOR:     pwm_floor    <= pwdata[7:0];
        REG_CEIL:      pwm_ceiling  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      REG_CURVE_0_1: prdata = cfg_curve[0];
      REG_CURVE_2_3: prdata = cfg_curve[1];
      REG_CURVE_4_5: prdata = cfg_curve[2];
      REG_CURVE_6_7: prdata = cfg_curve[3];
      REG_CURVE_8_9: prdata = cfg_curve[4];
      REG_FLOOR:     prdata = {24'd0, pwm_floor};
      REG_CEIL:      prdata = {24'd0, pwm_ceiling};
      default:       prdata = '0;
    endcase
  end

  // Next curve point, fetched one ahead of the point under test.
  logic [IDX_W-1:0] nidx;
  logic [31:0]      pair;
  point_t           nxt_pt;

  assign nidx = idx + IDX_W'(1);

  always_comb begin
    case (nidx[IDX_W-1:1])
      3'd0:    pair = cfg_curve[0];
      3'd1:    pair = cfg_curve[1];
      3'd2:    pair = cfg_curve[2];
      3'd3:    pair = cfg_curve[3];
      3'd4:    pair = cfg_curve[4];
      default: pair = '0;
    endcase
    nxt_pt = nidx[0] ? point_t'(pair[31:16]) : point_t'(pair[15:0]);
  end

  // Decision for the current point.
  logic  last_pt;
  walk_t walk_res;

  assign last_pt = (idx == IDX_W'(NUM_POINTS - 1));

  always_comb begin
    if (tracked < cur_pt.temp) begin
      walk_res = W_DIRECT;
    end else if (last_pt) begin
      walk_res = (tracked > cur_pt.temp) ? W_DIRECT : W_NOMATCH;
    end else if ((tracked > cur_pt.temp) && (cur_pt.temp >= nxt_pt.temp)) begin
      walk_res = W_DIRECT;
    end else if (tracked < nxt_pt.temp) begin
      walk_res = cur_pt.interp ? W_INTERP : W_DIRECT;
    end else begin
      walk_res = W_MORE;
    end
  end

  // Degree conversion and hysteresis bound.
  logic [TEMP_MILLI_W+18:0] conv_prod;
  logic [8:0]               deg_wide;
  logic [TEMP_W-1:0]        upper;

  assign conv_prod = TEMP_MILLI_W'(milli) * DEG_RECIP;
  assign deg_wide  = conv_prod[DEG_SHIFT +: 9];
  assign upper     = (deg > (TEMP_MAX - HYST)) ? TEMP_MAX : deg + HYST;

  // Two restoring division steps per cycle.
  logic [8:0] r1;
  logic [8:0] r1s;
  logic [8:0] r2;
  logic [8:0] r2s;
  logic       ge1;
  logic       ge2;

  always_comb begin
    r1  = {rem, quo[15]};
    ge1 = (r1 >= {1'b0, den});
    r1s = ge1 ? r1 - {1'b0, den} : r1;
    r2  = {r1s[7:0], quo[14]};
    ge2 = (r2 >= {1'b0, den});
    r2s = ge2 ? r2 - {1'b0, den} : r2;
  end

  // Control word and jump decision.
  always_comb begin
    uw = ucode(step);
    case (uw.cond)
      C_NEXT:      jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NO_IN:     jump = !in_ch.valid;
      C_WALK_MORE: jump = (walk_res == W_MORE);
      C_NOMATCH:   jump = w_nomatch;
      C_DIRECT:    jump = w_direct;
      C_DIV_MORE:  jump = (div_cnt != DIV_LAST);
      C_PCT_BAD:   jump = (pct > PCT_FULL);
      C_OUT_BUSY:  jump = out_valid;
      default:     jump = 1'b0;
    endcase
    step_next = jump ? uw.target : step + 4'd1;
  end

  assign in_ch.ready = (step == S_ACCEPT);

  // Sequencer, datapath and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= S_ACCEPT;
      tracked   <= '0;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;

      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end

      case (uw.op)
        OP_LOAD: begin
          milli <= in_ch.temp_milli;
        end
        OP_CONV: begin
          deg <= (deg_wide > {1'b0, TEMP_MAX}) ? TEMP_MAX : deg_wide[7:0];
        end
        OP_TRACK: begin
          if (tracked < deg) begin
            tracked <= deg;
          end else if (tracked > upper) begin
            tracked <= upper;
          end
          idx    <= '0;
          cur_pt <= point_t'(cfg_curve[0][15:0]);
        end
        OP_WALK: begin
          // Latch everything the chosen branch may need.
          w_direct  <= (walk_res == W_DIRECT);
          w_nomatch <= (walk_res == W_NOMATCH);
          pct       <= cur_pt.pct;
          neg       <= (nxt_pt.pct < cur_pt.pct);
          mag       <= (nxt_pt.pct < cur_pt.pct) ? {1'b0, cur_pt.pct - nxt_pt.pct}
                                                 : {1'b0, nxt_pt.pct - cur_pt.pct};
          dt        <= tracked - cur_pt.temp;
          den       <= nxt_pt.temp - cur_pt.temp;
          if (walk_res == W_MORE) begin
            idx    <= nidx;
            cur_pt <= nxt_pt;
          end
        end
        OP_MUL_INTERP: begin
          quo     <= mag * dt;
          rem     <= '0;
          div_cnt <= '0;
        end
        OP_DIV: begin
          rem     <= r2s[7:0];
          quo     <= {quo[13:0], ge1, ge2};
          div_cnt <= div_cnt + 3'd1;
        end
        OP_INTERP_DONE: begin
          pct <= neg ? pct - quo[6:0] : pct + quo[6:0];
        end
        OP_SCALE_SETUP: begin
          neg     <= (pwm_ceiling < pwm_floor);
          quo     <= 16'((pwm_ceiling < pwm_floor) ? pwm_floor - pwm_ceiling
                                                   : pwm_ceiling - pwm_floor)
                     * {9'd0, pct};
          den     <= {1'b0, PCT_FULL};
          rem     <= '0;
          div_cnt <= '0;
        end
        OP_SCALE_DONE: begin
          res_pwm <= neg ? pwm_floor - quo[7:0] : pwm_floor + quo[7:0];
          res_pct <= pct;
          res_ok  <= 1'b1;
        end
        OP_FAIL: begin
          res_pwm <= '0;
          res_pct <= '0;
          res_ok  <= 1'b0;
        end
        OP_WRITE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_pwm   <= res_pwm;
            out_pct   <= res_pct;
            out_track <= tracked;
            out_deg   <= deg;
            out_ok    <= res_ok;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.pwm_value        = out_pwm;
  assign out_ch.duty_pct         = out_pct;
  assign out_ch.tracked_temp_out = out_track;
  assign out_ch.real_temp        = out_deg;
  assign out_ch.valid_res        = out_ok;

  // An invalid result carries zero PWM and zero duty.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ok) |-> (out_pwm == '0) && (out_pct == '0))
    else $error("invalid result with non-zero payload");

  // A valid result never has a duty above one hundred percent.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ok) |-> (out_pct <= PCT_FULL))
    else $error("valid result with duty above full scale");

  // The tracked temperature lies between the sample and the hysteresis bound.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, out_track} >= {1'b0, out_deg}) &&
                  ({1'b0, out_track} <= ({1'b0, out_deg} + 9'd5)))
    else $error("tracked temperature outside hysteresis window");

  // Interpolation divides by a non-zero segment width.
  assert property (@(posedge clk) disable iff (rst)
    (step == S_IDIV) |-> (den != '0))
    else $error("interpolation divisor is zero");

  // The interpolation division starts from a cleared step count.
  assert property (@(posedge clk) disable iff (rst)
    ((step == S_IDIV) && ($past(step) == S_IMUL)) |-> (div_cnt == '0))
    else $error("division entered with a stale step count");

endmodule
